/* sv/whs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// whs_pkg
// Shared types and constants for the wee hash stream unit.
// ----------------------------------------------------------------------------
package whs_pkg;

    localparam int unsigned ROUNDS      = 4;
    localparam int unsigned RND_W       = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned K_W     = 8;
    localparam int unsigned NB_W    = 4;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned WORD_BYTES = 8;

    localparam logic [K_W-1:0] WH_A   = K_W'(123);
    localparam logic [K_W-1:0] WH_C64 = K_W'(123 + 128);
    localparam logic [K_W-1:0] WH_C32 = K_W'(123 + 64);

    localparam logic [MODE_W-1:0] MODE_MSG   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEY64 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEY32 = 2'd2;

    typedef enum logic [2:0] {
        OP_MSG_MID,
        OP_MSG_END,
        OP_MSG_EMPTY,
        OP_KEY64,
        OP_KEY32
    } whs_kind_t;

    typedef struct packed {
        whs_kind_t          kind;
        logic [WORD_W-1:0]  key;
        logic [WORD_W-1:0]  seed;
        logic               use_seed;
        logic [K_W-1:0]     k;
    } whs_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } whs_q_status_t;

endpackage
`default_nettype wire

/* sv/whs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// whs_front
// Holds the mode register, accepts input items and turns each one into a
// work entry: operation kind, masked key, round constant and seed select.
// ----------------------------------------------------------------------------
module whs_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [whs_pkg::MODE_W-1:0]     cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [63:0]                    data_word,
    input  wire logic [3:0]                     valid_bytes,
    input  wire logic                           is_first,
    input  wire logic                           is_last,
    input  wire logic [63:0]                    seed,
    input  wire whs_pkg::whs_q_status_t         q_status,
    output logic                                push,
    output whs_pkg::whs_item_t                  push_item
);

    logic [whs_pkg::MODE_W-1:0] mode_reg;
    logic [whs_pkg::NB_W-1:0]   nb;
    logic [63:0]                byte_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= whs_pkg::MODE_MSG;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    assign in_ready = !q_status.full;
    assign push     = in_valid && !q_status.full;

    assign nb = (valid_bytes > whs_pkg::NB_W'(whs_pkg::WORD_BYTES))
              ? whs_pkg::NB_W'(whs_pkg::WORD_BYTES) : valid_bytes;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_mask[8*i +: 8] = (whs_pkg::NB_W'(i) < nb) ? 8'hFF : 8'h00;
        end
    end

    always_comb
    begin
        push_item.key      = data_word;
        push_item.seed     = seed;
        push_item.use_seed = 1'b1;
        push_item.k        = whs_pkg::WH_C64;
        push_item.kind     = whs_pkg::OP_KEY64;
        unique case (mode_reg)
            whs_pkg::MODE_KEY64:
            begin
                push_item.kind = whs_pkg::OP_KEY64;
            end
            whs_pkg::MODE_KEY32:
            begin
                push_item.kind = whs_pkg::OP_KEY32;
                push_item.key  = {32'b0, data_word[31:0]};
                push_item.seed = {32'b0, seed[31:0]};
                push_item.k    = whs_pkg::WH_C32;
            end
            default:
            begin
                push_item.use_seed = is_first;
                if (!is_last)
                begin
                    push_item.kind = whs_pkg::OP_MSG_MID;
                end
                else if (nb == '0)
                begin
                    push_item.kind = whs_pkg::OP_MSG_EMPTY;
                end
                else
                begin
                    push_item.kind = whs_pkg::OP_MSG_END;
                    push_item.key  = data_word & byte_mask;
                    push_item.k    = whs_pkg::WH_A + {3'b0, nb, 1'b0};
                end
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/whs_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// whs_fifo
// Short queue of work entries between the front and the back.
// ----------------------------------------------------------------------------
module whs_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire whs_pkg::whs_item_t push_item,
    input  wire logic               pop,
    output whs_pkg::whs_item_t      pop_item,
    output whs_pkg::whs_q_status_t  status
);

    whs_pkg::whs_item_t              mem [whs_pkg::QUEUE_DEPTH];
    logic [whs_pkg::PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [whs_pkg::PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [whs_pkg::CNT_W-1:0]       count_reg, count_next;

    assign status.full  = (count_reg == whs_pkg::CNT_W'(whs_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == whs_pkg::PTR_W'(whs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == whs_pkg::PTR_W'(whs_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* sv/whs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// whs_back
// Runs the hash rounds on one work entry at a time, forming each 64-bit
// product from 32-bit partial products in a lower and an upper multiply
// phase, keeps the running hash and drives the output register.
// ----------------------------------------------------------------------------
module whs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire whs_pkg::whs_q_status_t q_status,
    input  wire whs_pkg::whs_item_t  pop_item,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [63:0]              hash_value
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    whs_pkg::whs_kind_t          kind_reg, kind_next;
    logic [whs_pkg::K_W-1:0]     k_reg, k_next;
    logic [whs_pkg::RND_W-1:0]   rnd_reg, rnd_next;
    logic [63:0]                 x_reg, x_next;
    logic [63:0]                 a_reg, a_next;
    logic [63:0]                 p0_reg, p0_next;
    logic [31:0]                 c1_reg, c1_next;
    logic [63:0]                 run_reg, run_next;
    logic                        out_valid_reg, out_valid_next;
    logic [63:0]                 hash_reg, hash_next;

    logic        w32;
    logic [63:0] h_sel;
    logic [63:0] x_load;
    logic [63:0] a_full;
    logic [31:0] c2;
    logic [63:0] f;
    logic [63:0] x_round;

    assign w32     = (kind_reg == whs_pkg::OP_KEY32);
    assign h_sel   = pop_item.use_seed ? pop_item.seed : run_reg;
    assign x_load  = pop_item.key + h_sel;
    assign a_full  = {x_reg[62:0], 1'b0} + 64'(k_reg);
    assign c2      = a_reg[31:0] * x_reg[63:32];
    assign f       = p0_reg + {c1_reg + c2, 32'b0};
    assign x_round = w32 ? {32'b0, f[15:0], f[31:16]} : {f[31:0], f[63:32]};

    assign pop        = (state_reg == S_IDLE) && !q_status.empty;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        k_next         = k_reg;
        rnd_next       = rnd_reg;
        x_next         = x_reg;
        a_next         = a_reg;
        p0_next        = p0_reg;
        c1_next        = c1_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hash_next      = hash_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    kind_next = pop_item.kind;
                    k_next    = pop_item.k;
                    rnd_next  = '0;
                    if (pop_item.kind == whs_pkg::OP_MSG_EMPTY)
                    begin
                        x_next     = h_sel;
                        state_next = S_DONE;
                    end
                    else if (pop_item.kind == whs_pkg::OP_KEY32)
                    begin
                        x_next     = {32'b0, x_load[31:0]};
                        state_next = S_MUL_LO;
                    end
                    else
                    begin
                        x_next     = x_load;
                        state_next = S_MUL_LO;
                    end
                end
            end
            S_MUL_LO:
            begin
                a_next     = w32 ? {32'b0, a_full[31:0]} : a_full;
                p0_next    = 64'(a_next[31:0]) * 64'(x_reg[31:0]);
                c1_next    = a_next[63:32] * x_reg[31:0];
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                x_next = x_round;
                if (rnd_reg == whs_pkg::RND_W'(whs_pkg::ROUNDS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rnd_next   = rnd_reg + 1'b1;
                    state_next = S_MUL_LO;
                end
            end
            S_DONE:
            begin
                if (kind_reg == whs_pkg::OP_MSG_MID)
                begin
                    run_next   = x_reg;
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = x_reg;
                    if (kind_reg == whs_pkg::OP_MSG_END || kind_reg == whs_pkg::OP_MSG_EMPTY)
                    begin
                        run_next = x_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rnd_reg       <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        k_reg    <= k_next;
        x_reg    <= x_next;
        a_reg    <= a_next;
        p0_reg   <= p0_next;
        c1_reg   <= c1_next;
        hash_reg <= hash_next;
    end

    a_hi_follows_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_HI) |-> ($past(state_reg) == S_MUL_LO))
        else $error("Upper multiply phase entered without the lower phase.");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg <= whs_pkg::RND_W'(whs_pkg::ROUNDS - 1))
        else $error("Round counter ran past the last round.");

    a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && kind_reg == whs_pkg::OP_KEY32) |-> (x_reg[63:32] == '0))
        else $error("32-bit key hash carries bits in the upper half.");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("Result item shown without a finished work entry.");

endmodule
`default_nettype wire

/* sv/wee_hash_stream_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wee_hash_stream_unit
// Wee hash over streamed message words or single 64-bit and 32-bit keys.
// ----------------------------------------------------------------------------
// Input items are classified on arrival and placed in a two-entry queue, so
// the input side keeps taking items while the hash engine works and the
// queue has room. The engine handles one queued item at a time: a word that
// runs the hash block passes, per round, through a lower and an upper
// multiply phase (the 64-bit product is built from 32-bit partial products),
// then a done state; an empty final word goes straight to the done state. A
// message word depends on the running hash left by the word before it. The
// result sits in an output register, and the engine goes on with the next
// item while the result waits to be taken; an item that has a result of its
// own waits at its end until the register is free. The user writes the mode
// register only while the unit holds no unfinished item; this is not enforced.
// ----------------------------------------------------------------------------
module wee_hash_stream_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [whs_pkg::MODE_W-1:0]     cfg_wr_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [63:0]                    data_word,
    input  wire logic [3:0]                     valid_bytes,
    input  wire logic                           is_first,
    input  wire logic                           is_last,
    input  wire logic [63:0]                    seed,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [63:0]                         hash_value
);

    whs_pkg::whs_q_status_t  q_status;
    whs_pkg::whs_item_t      push_item;
    whs_pkg::whs_item_t      pop_item;
    logic                    push;
    logic                    pop;

    whs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .is_first    (is_first),
        .is_last     (is_last),
        .seed        (seed),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    whs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    whs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_item   (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wee hash stream unit. A queue of pending items
// feeds a clocked driver, which predicts the hash of each accepted item. A
// clocked monitor compares each result item with the oldest predicted hash.
// The run covers directed corner cases and random messages and keys in all
// modes, with random gaps on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [whs_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
        logic [63:0] seed;
    } msg_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [whs_pkg::MODE_W-1:0]   cfg_wr_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [63:0]                  data_word = '0;
    logic [3:0]                   valid_bytes = '0;
    logic                         is_first = 1'b0;
    logic                         is_last = 1'b0;
    logic [63:0]                  seed = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [63:0]                  hash_value;

    msg_word_t                    pending[$];
    logic [63:0]                  hash_due[$];
    logic [whs_pkg::MODE_W-1:0]   pred_mode = whs_pkg::MODE_MSG;
    logic [63:0]                  chain_hash = '0;
    logic [63:0]                  next_hash;
    msg_word_t                    drv_word;
    logic [63:0]                  due_hash;
    logic                         quiet = 1'b0;
    int                           gap_cnt = 0;
    int                           stall_cnt = 0;
    int                           n_results = 0;
    int                           n_items = 0;
    int                           err_cnt = 0;
    int                           cycle_cnt = 0;

    wee_hash_stream_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .is_first    (is_first),
        .is_last     (is_last),
        .seed        (seed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash_value  (hash_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] mix64(input logic [63:0] h, input logic [63:0] key,
                                          input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] f;
        int          i;
        x = key + h;
        for (i = 0; i < whs_pkg::ROUNDS; i++)
        begin
            f = ((x << 1) + k) * x;
            x = {f[31:0], f[63:32]};
        end
        return x;
    endfunction

    function automatic logic [31:0] mix32(input logic [31:0] h, input logic [31:0] key);
        logic [31:0] x;
        logic [31:0] f;
        int          i;
        x = key + h;
        for (i = 0; i < whs_pkg::ROUNDS; i++)
        begin
            f = ((x << 1) + 32'(whs_pkg::WH_C32)) * x;
            x = {f[15:0], f[31:16]};
        end
        return x;
    endfunction

    function automatic logic predict_hash(input logic [63:0] word, input logic [3:0] nb_in,
                                          input logic first, input logic last,
                                          input logic [63:0] sd, output logic [63:0] h_out);
        logic [63:0] h;
        logic [63:0] w;
        int unsigned nb;
        h_out = '0;
        if (pred_mode == whs_pkg::MODE_KEY64)
        begin
            h_out = mix64(sd, word, 64'(whs_pkg::WH_C64));
            return 1'b1;
        end
        if (pred_mode == whs_pkg::MODE_KEY32)
        begin
            h_out = {32'd0, mix32(sd[31:0], word[31:0])};
            return 1'b1;
        end
        h = first ? sd : chain_hash;
        if (!last)
        begin
            chain_hash = mix64(h, word, 64'(whs_pkg::WH_C64));
            return 1'b0;
        end
        nb = (nb_in > whs_pkg::WORD_BYTES) ? whs_pkg::WORD_BYTES : nb_in;
        if (nb != 0)
        begin
            w = word;
            if (nb < whs_pkg::WORD_BYTES)
                w = word & ((64'd1 << (8 * nb)) - 64'd1);
            h = mix64(h, w, 64'(whs_pkg::WH_A) + 64'(2 * nb));
        end
        chain_hash = h;
        h_out = h;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_cnt = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (predict_hash(data_word, valid_bytes, is_first, is_last, seed, next_hash))
                    hash_due.push_back(next_hash);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    in_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    drv_word = pending.pop_front();
                    data_word <= drv_word.data;
                    valid_bytes <= drv_word.nbytes;
                    is_first <= drv_word.first;
                    is_last <= drv_word.last;
                    seed <= drv_word.seed;
                    in_valid <= 1'b1;
                    gap_cnt = quiet ? 0 : $urandom_range(0, 15);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_cnt = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (hash_due.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected result item: hash %h", hash_value);
                    err_cnt++;
                end
                else
                begin
                    due_hash = hash_due.pop_front();
                    if (hash_value !== due_hash)
                    begin
                        if (err_cnt < 10)
                            $display("hash mismatch: expected %h, actual %h",
                                     due_hash, hash_value);
                        err_cnt++;
                    end
                end
                if (n_results == 30 || n_results == 500)
                    stall_cnt = HOLD_CYCLES;
                else
                    stall_cnt = quiet ? 0 : $urandom_range(0, 15);
            end
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL wee_hash_stream_unit");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic add_word(input logic [63:0] data, input logic [3:0] nb, input logic first,
                            input logic last, input logic [63:0] sd);
        msg_word_t w;
        w.data = data;
        w.nbytes = nb;
        w.first = first;
        w.last = last;
        w.seed = sd;
        pending.push_back(w);
        n_items++;
    endtask

    task automatic add_message();
        int          n_mid;
        int          i;
        int unsigned r;
        logic [63:0] sd;
        logic [3:0]  nb;
        logic        fst;
        n_mid = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        sd = rand64();
        fst = ($urandom_range(0, 9) != 0);
        for (i = 0; i < n_mid; i++)
            add_word(rand64(), 4'($urandom_range(0, 15)),
                     (i == 0) ? fst : ($urandom_range(0, 19) == 0), 1'b0, sd);
        r = $urandom_range(0, 19);
        if (r == 0)
            nb = 4'd0;
        else if (r == 1)
            nb = 4'($urandom_range(9, 15));
        else
            nb = 4'($urandom_range(1, 8));
        add_word(rand64(), nb, (n_mid == 0) ? fst : ($urandom_range(0, 19) == 0), 1'b1, sd);
    endtask

    task automatic add_noise();
        add_word(rand64(), 4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom), rand64());
    endtask

    task automatic drain();
        while (pending.size() != 0 || in_valid || hash_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic [whs_pkg::MODE_W-1:0] m);
        drain();
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        pred_mode <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [whs_pkg::MODE_W-1:0] m;
        int unsigned                r;
        int                         target;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Message mode straight out of reset: empty messages, masking, long counts.
        add_word(64'h0123_4567_89ab_cdef, 4'd0, 1'b1, 1'b1, 64'hdead_beef_cafe_f00d);
        add_word(64'hffff_ffff_ffff_ffff, 4'd0, 1'b0, 1'b1, 64'h0);
        add_word('1, 4'd8, 1'b1, 1'b1, '1);
        add_word('0, 4'd8, 1'b1, 1'b1, '0);
        add_word('1, 4'd1, 1'b1, 1'b1, 64'h5555_aaaa_5555_aaaa);
        add_word('1, 4'd15, 1'b1, 1'b1, '0);
        add_word(64'h8877_6655_4433_2211, 4'd9, 1'b0, 1'b1, '1);
        add_word('1, 4'd3, 1'b1, 1'b0, '1);
        add_word('1, 4'd7, 1'b0, 1'b1, '0);
        add_word(rand64(), 4'd12, 1'b0, 1'b0, '0);
        add_word(rand64(), 4'd5, 1'b1, 1'b0, 64'h1);
        add_word(rand64(), 4'd0, 1'b0, 1'b1, '1);

        set_mode(whs_pkg::MODE_KEY64);
        add_word('0, 4'd0, 1'b0, 1'b0, '0);
        add_word('1, 4'd15, 1'b1, 1'b1, '1);
        add_word(rand64(), 4'd4, 1'b0, 1'b1, rand64());

        set_mode(whs_pkg::MODE_KEY32);
        add_word('1, 4'd0, 1'b1, 1'b0, '1);
        add_word('0, 4'd8, 1'b0, 1'b1, '0);
        add_word(64'hffff_ffff_0000_0001, 4'd2, 1'b1, 1'b1, 64'h1234_5678_ffff_fffe);

        set_mode(MODE_SPARE);
        add_word(rand64(), 4'd6, 1'b1, 1'b0, rand64());
        add_word(rand64(), 4'd2, 1'b0, 1'b1, '0);

        set_mode(whs_pkg::MODE_MSG);
        while (n_items < 1020)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                m = whs_pkg::MODE_MSG;
            else if (r < 7)
                m = whs_pkg::MODE_KEY64;
            else if (r < 9)
                m = whs_pkg::MODE_KEY32;
            else
                m = MODE_SPARE;
            set_mode(m);
            quiet = ($urandom_range(0, 3) == 0);
            target = n_items + $urandom_range(40, 120);
            while (n_items < target)
            begin
                if (m == whs_pkg::MODE_KEY64 || m == whs_pkg::MODE_KEY32
                    || $urandom_range(0, 9) == 0)
                    add_noise();
                else
                    add_message();
            end
        end

        drain();
        if (err_cnt == 0 && hash_due.size() == 0)
            $display("PASS wee_hash_stream_unit");
        else
            $display("FAIL wee_hash_stream_unit");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
sv/whs_pkg.sv
sv/whs_front.sv
sv/whs_fifo.sv
sv/whs_back.sv
sv/wee_hash_stream_unit.sv
tb/testbench.sv
